### hw/rtl/path_heading_filter_macros.svh
// Assertion macros for the path heading filter.
// Included by the top level; no other dependencies.
`ifndef PATH_HEADING_FILTER_MACROS_SVH
`define PATH_HEADING_FILTER_MACROS_SVH
// Check that a condition holds in the cycle after a trigger, outside reset.
`define PHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("path_heading_filter: next-cycle check failed");
// Check the state that follows a reset cycle.
`define PHF_ASSERT_AFTER_RESET(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("path_heading_filter: post-reset check failed");
`endif

### hw/rtl/phf_pkg.sv
// Shared types, constants and the arctangent table of the path heading filter.
// No dependencies.
package phf_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670675, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    localparam int YAW_TOL_W  = 16;
    localparam int GAP_TOL_W  = 31;
    localparam int CFG_DATA_W = 31;
    localparam int QUAT_W     = 16;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_YAW_TOL = 2'd0;
    localparam cfg_index_t REG_GAP_TOL = 2'd1;

    localparam logic [YAW_TOL_W-1:0] YAW_TOL_RESET = 16'd2608;
    localparam logic [GAP_TOL_W-1:0] GAP_TOL_RESET = 31'd16384;

    typedef enum logic [2:0] {
        SRC_PEN, SRC_QUAT, SRC_IN, ROT_PREV, ROT_ZERO, ROT_CUR
    } cordic_src_t;

    typedef enum logic [1:0] {
        OUT_NONE, OUT_ANCHOR, OUT_GOAL
    } out_sel_t;

    typedef enum logic [2:0] {
        GAP_NONE, GAP_DX, GAP_DY, GAP_G, GAP_DECIDE
    } gap_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_RUN_PEN, ST_QMUL, ST_QSTART, ST_RUN_QUAT,
        ST_WO_START, ST_RUN_WO, ST_GAP_DX, ST_GAP_DY, ST_GAP_G, ST_DECIDE,
        ST_KEEP, ST_RUN_ROTK, ST_EMIT_K, ST_TAIL, ST_RUN_HEAD, ST_HROT,
        ST_RUN_ROTF, ST_EMIT_F, ST_EMIT_G
    } phf_state_t;

    typedef struct packed {
        logic        cap_in;
        logic        start;
        cordic_src_t src;
        logic        step;
        logic        save_prev;
        logic        save_this;
        logic        save_wo;
        logic        qmul;
        gap_op_t     gap_op;
        logic        anc_from_in;
        logic        anc_from_pen;
        logic        pen_from_in;
        out_sel_t    out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic keep;
        logic last_pose;
        logic out_free;
    } dp_status_t;

    // Arctangent of 2^-idx as a fraction of a turn, rounded to the given bits.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx, input int bits);
        int sh;
        logic [31:0] v;
        sh = 32 - bits;
        v = '0;
        if (idx < 5'(TABLE_LEN)) begin
            v = (ATAN_TURN32[idx] + (32'd1 << (sh - 1))) >> sh;
        end
        return v;
    endfunction

endpackage

### hw/rtl/path_heading_filter.sv
// Path heading filter: one pose request at a time through one shared CORDIC unit
// at one micro-rotation per cycle. A non-final pose is only stored while filling;
// with anchor and pending held, the pending pose is dropped or kept, and keeping it
// emits the anchor; a goal pose emits the anchor and the goal, both after output stalls.
// The output register holds one result while the next request may be taken.
// Synchronous active-low reset empties the path, drops m_valid, restores tolerances.
`include "path_heading_filter_macros.svh"
module path_heading_filter #(
    parameter int POS_BITS     = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [POS_BITS-1:0]        s_pos_x,
    input  logic signed [POS_BITS-1:0]        s_pos_y,
    input  logic signed [phf_pkg::QUAT_W-1:0] s_quat_z,
    input  logic signed [phf_pkg::QUAT_W-1:0] s_quat_w,
    input  logic                              s_last_pose,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [POS_BITS-1:0]        m_out_x,
    output logic signed [POS_BITS-1:0]        m_out_y,
    output logic signed [phf_pkg::QUAT_W-1:0] m_out_qz,
    output logic signed [phf_pkg::QUAT_W-1:0] m_out_qw,
    output logic                              m_end_of_path,
    input  logic                              cfg_wr_en,
    input  phf_pkg::cfg_index_t               cfg_index,
    input  logic [phf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import phf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    phf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    phf_datapath #(
        .POS_BITS     (POS_BITS),
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_quat_z      (s_quat_z),
        .s_quat_w      (s_quat_w),
        .s_last_pose   (s_last_pose),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_qz      (m_out_qz),
        .m_out_qw      (m_out_qw),
        .m_end_of_path (m_end_of_path)
    );

    `PHF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PHF_ASSERT_AFTER_RESET(a_reset_idle, aclk, aresetn, !m_valid && s_ready)

endmodule

### hw/rtl/phf_cordic.sv
// Shared iterative CORDIC unit: vectoring (heading) or rotation (half sin/cos).
// One micro-rotation per step; uses phf_pkg for the arctangent table.
module phf_cordic #(
    parameter int W          = 35,
    parameter int ZW         = 18,
    parameter int ANGLE_BITS = 16,
    parameter int STEPS      = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 rotate,
    input  logic signed [W-1:0]  x_init,
    input  logic signed [W-1:0]  y_init,
    input  logic signed [ZW-1:0] z_init,
    input  logic                 step,
    output logic signed [W-1:0]  x,
    output logic signed [W-1:0]  y,
    output logic signed [ZW-1:0] z,
    output logic                 last
);
    import phf_pkg::*;

    localparam int CW = $clog2(STEPS);

    logic signed [W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rot_reg, rot_next;

    logic signed [W-1:0]  sx, sy;
    logic signed [ZW-1:0] a;
    logic                 up;

    always_comb begin
        sx = x_reg >>> cnt_reg;
        sy = y_reg >>> cnt_reg;
        a  = signed'(ZW'(atan_entry(5'(cnt_reg), rot_reg ? ANGLE_BITS + 1 : ANGLE_BITS)));
        up = rot_reg ? z_reg[ZW-1] : (y_reg > 0);
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        cnt_next = cnt_reg;
        rot_next = rot_reg;
        if (start) begin
            x_next   = x_init;
            y_next   = y_init;
            z_next   = z_init;
            cnt_next = '0;
            rot_next = rotate;
        end else if (step) begin
            if (up) begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + a;
            end else begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - a;
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rot_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rot_reg <= rot_next;
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign last = (cnt_reg == CW'(STEPS - 1));

endmodule

### hw/rtl/phf_datapath.sv
// Datapath: pose registers, CORDIC sources, gap test, config and output register.
// Depends on phf_pkg and phf_cordic.
module phf_datapath #(
    parameter int POS_BITS     = 32,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  phf_pkg::ctrl_cmd_t                  cmd,
    output phf_pkg::dp_status_t                 status,
    input  logic signed [POS_BITS-1:0]          s_pos_x,
    input  logic signed [POS_BITS-1:0]          s_pos_y,
    input  logic signed [phf_pkg::QUAT_W-1:0]   s_quat_z,
    input  logic signed [phf_pkg::QUAT_W-1:0]   s_quat_w,
    input  logic                                s_last_pose,
    input  logic                                cfg_wr_en,
    input  phf_pkg::cfg_index_t                 cfg_index,
    input  logic [phf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic signed [POS_BITS-1:0]          m_out_x,
    output logic signed [POS_BITS-1:0]          m_out_y,
    output logic signed [phf_pkg::QUAT_W-1:0]   m_out_qz,
    output logic signed [phf_pkg::QUAT_W-1:0]   m_out_qw,
    output logic                                m_end_of_path
);
    import phf_pkg::*;

    localparam int DW  = POS_BITS + 1;
    localparam int VW  = ((DW > 33) ? DW : 33) + 2;
    localparam int ZW  = ANGLE_BITS + 2;
    localparam int DXW = (DW > 32) ? DW : 32;
    localparam int CMPW = 25;

    localparam logic signed [VW-1:0] Q30_ONE = VW'(64'sd1 << 30);
    localparam logic signed [VW-1:0] KINV    = VW'(64'sd652032874);
    localparam logic signed [VW-1:0] RND     = VW'(64'sd16384);
    localparam logic signed [VW-1:0] Q15_MAX = VW'(64'sd32767);
    localparam logic signed [VW-1:0] Q15_MIN = -VW'(64'sd32768);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 << (ANGLE_BITS - 2));

    // captured request, anchor and pending poses
    logic signed [POS_BITS-1:0] in_x_reg, in_y_reg, anc_x_reg, anc_y_reg, pen_x_reg, pen_y_reg;
    logic signed [QUAT_W-1:0]   in_qz_reg, in_qw_reg, pen_qz_reg, pen_qw_reg;
    logic                       in_last_reg;
    logic signed [31:0]         wz_reg, zz_reg;
    logic                       zero_reg;
    logic [ANGLE_BITS-1:0]      yaw_prev_reg, yaw_this_reg, yaw_wo_reg;
    logic [61:0]                prod_reg;
    logic [62:0]                acc_reg;
    logic                       keep_reg;
    logic [YAW_TOL_W-1:0]       yaw_tol_reg;
    logic [GAP_TOL_W-1:0]       gap_tol_reg;
    logic                       m_valid_reg, m_valid_next;
    logic signed [POS_BITS-1:0] out_x_reg, out_y_reg;
    logic signed [QUAT_W-1:0]   out_qz_reg, out_qw_reg;
    logic                       out_eop_reg;

    logic signed [DW-1:0]  pen_dx, pen_dy, in_dx, in_dy;
    logic signed [VW-1:0]  vx_raw, vy_raw, vx, vy, x_init, y_init;
    logic signed [ZW-1:0]  vz, z_init;
    logic [ANGLE_BITS-1:0] rot_yaw, yaw_cur;
    logic                  rotate;
    logic signed [VW-1:0]  cx, cy;
    logic signed [ZW-1:0]  cz;
    logic                  c_last;

    logic [ANGLE_BITS-1:0] d_prev, d_this, m_prev, m_this;
    logic                  ang_ok;
    logic signed [DXW-1:0] pdx_e, pdy_e;
    logic [DXW-1:0]        abs_x, abs_y;
    logic                  big;
    logic [GAP_TOL_W-1:0]  mul_op;
    logic [61:0]           sq;

    function automatic logic [QUAT_W-1:0] q15_round(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] r;
        logic [QUAT_W-1:0]    q;
        r = (v + RND) >>> 15;
        if (r > Q15_MAX) begin
            q = 16'h7fff;
        end else if (r < Q15_MIN) begin
            q = 16'h8000;
        end else begin
            q = r[QUAT_W-1:0];
        end
        return q;
    endfunction

    assign pen_dx = DW'(pen_x_reg) - DW'(anc_x_reg);
    assign pen_dy = DW'(pen_y_reg) - DW'(anc_y_reg);
    assign in_dx  = DW'(in_x_reg) - DW'(anc_x_reg);
    assign in_dy  = DW'(in_y_reg) - DW'(anc_y_reg);

    // pick the CORDIC operands and pre-rotate the left half plane
    always_comb begin
        case (cmd.src)
            SRC_PEN: begin
                vx_raw = VW'(pen_dx);
                vy_raw = VW'(pen_dy);
            end
            SRC_QUAT: begin
                vx_raw = Q30_ONE - (VW'(zz_reg) <<< 1);
                vy_raw = VW'(wz_reg) <<< 1;
            end
            default: begin
                vx_raw = VW'(in_dx);
                vy_raw = VW'(in_dy);
            end
        endcase
        vx = vx_raw;
        vy = vy_raw;
        vz = '0;
        if (vx_raw < 0) begin
            if (vy_raw >= 0) begin
                vx = vy_raw;
                vy = -vx_raw;
                vz = QUARTER;
            end else begin
                vx = -vy_raw;
                vy = vx_raw;
                vz = -QUARTER;
            end
        end
        rotate = (cmd.src == ROT_PREV) || (cmd.src == ROT_ZERO) || (cmd.src == ROT_CUR);
        case (cmd.src)
            ROT_PREV: rot_yaw = yaw_prev_reg;
            ROT_ZERO: rot_yaw = '0;
            default:  rot_yaw = yaw_cur;
        endcase
        x_init = rotate ? KINV : vx;
        y_init = rotate ? '0 : vy;
        z_init = rotate ? ZW'(signed'(rot_yaw)) : vz;
    end

    assign yaw_cur = zero_reg ? '0 : cz[ANGLE_BITS-1:0];

    phf_cordic #(
        .W          (VW),
        .ZW         (ZW),
        .ANGLE_BITS (ANGLE_BITS),
        .STEPS      (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .rotate  (rotate),
        .x_init  (x_init),
        .y_init  (y_init),
        .z_init  (z_init),
        .step    (cmd.step),
        .x       (cx),
        .y       (cy),
        .z       (cz),
        .last    (c_last)
    );

    // heading differences against the tolerance
    always_comb begin
        d_prev = yaw_prev_reg - yaw_wo_reg;
        d_this = yaw_this_reg - yaw_wo_reg;
        m_prev = d_prev[ANGLE_BITS-1] ? -d_prev : d_prev;
        m_this = d_this[ANGLE_BITS-1] ? -d_this : d_this;
        ang_ok = (CMPW'(m_prev) < CMPW'(yaw_tol_reg)) && (CMPW'(m_this) < CMPW'(yaw_tol_reg));
    end

    // squared gap: any offset past 31 bits already beats the largest tolerance
    always_comb begin
        pdx_e = DXW'(pen_dx);
        pdy_e = DXW'(pen_dy);
        abs_x = pdx_e[DXW-1] ? DXW'(-pdx_e) : DXW'(pdx_e);
        abs_y = pdy_e[DXW-1] ? DXW'(-pdy_e) : DXW'(pdy_e);
        big   = (|abs_x[DXW-1:31]) || (|abs_y[DXW-1:31]);
        case (cmd.gap_op)
            GAP_DX:  mul_op = abs_x[30:0];
            GAP_DY:  mul_op = abs_y[30:0];
            default: mul_op = gap_tol_reg;
        endcase
        sq = 62'(mul_op) * 62'(mul_op);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            in_x_reg    <= s_pos_x;
            in_y_reg    <= s_pos_y;
            in_qz_reg   <= s_quat_z;
            in_qw_reg   <= s_quat_w;
            in_last_reg <= s_last_pose;
        end
        if (cmd.anc_from_in) begin
            anc_x_reg <= in_x_reg;
            anc_y_reg <= in_y_reg;
        end else if (cmd.anc_from_pen) begin
            anc_x_reg <= pen_x_reg;
            anc_y_reg <= pen_y_reg;
        end
        if (cmd.pen_from_in) begin
            pen_x_reg  <= in_x_reg;
            pen_y_reg  <= in_y_reg;
            pen_qz_reg <= in_qz_reg;
            pen_qw_reg <= in_qw_reg;
        end
        if (cmd.qmul) begin
            wz_reg <= 32'(pen_qw_reg) * 32'(pen_qz_reg);
            zz_reg <= 32'(pen_qz_reg) * 32'(pen_qz_reg);
        end
        if (cmd.start) begin
            zero_reg <= !rotate && (vx_raw == '0) && (vy_raw == '0);
        end
        if (cmd.save_prev) yaw_prev_reg <= yaw_cur;
        if (cmd.save_this) yaw_this_reg <= yaw_cur;
        if (cmd.save_wo)   yaw_wo_reg   <= yaw_cur;
        case (cmd.gap_op)
            GAP_DX: prod_reg <= sq;
            GAP_DY: begin
                acc_reg  <= {1'b0, prod_reg};
                prod_reg <= sq;
            end
            GAP_G: begin
                acc_reg  <= acc_reg + {1'b0, prod_reg};
                prod_reg <= sq;
            end
            GAP_DECIDE: keep_reg <= ang_ok || big || (acc_reg >= {1'b0, prod_reg});
            default: ;
        endcase
        case (cmd.out_sel)
            OUT_ANCHOR: begin
                out_x_reg   <= anc_x_reg;
                out_y_reg   <= anc_y_reg;
                out_qz_reg  <= q15_round(cy);
                out_qw_reg  <= q15_round(cx);
                out_eop_reg <= 1'b0;
            end
            OUT_GOAL: begin
                out_x_reg   <= in_x_reg;
                out_y_reg   <= in_y_reg;
                out_qz_reg  <= in_qz_reg;
                out_qw_reg  <= in_qw_reg;
                out_eop_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.out_sel != OUT_NONE) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            yaw_tol_reg <= YAW_TOL_RESET;
            gap_tol_reg <= GAP_TOL_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_YAW_TOL: yaw_tol_reg <= cfg_data[YAW_TOL_W-1:0];
                    REG_GAP_TOL: gap_tol_reg <= cfg_data[GAP_TOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign status.cordic_last = c_last;
    assign status.keep        = keep_reg;
    assign status.last_pose   = in_last_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_out_qz      = out_qz_reg;
    assign m_out_qw      = out_qw_reg;
    assign m_end_of_path = out_eop_reg;

endmodule

### hw/rtl/phf_ctrl.sv
// Controller: sequences the CORDIC runs, gap test and result loads per request.
// Depends on phf_pkg.
module phf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  phf_pkg::dp_status_t status,
    output phf_pkg::ctrl_cmd_t  cmd
);
    import phf_pkg::*;

    phf_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.cap_in = s_valid;
                if (s_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (phase_reg)
                    2'd2: begin
                        cmd.start  = 1'b1;
                        cmd.src    = SRC_PEN;
                        state_next = ST_RUN_PEN;
                    end
                    2'd1: begin
                        state_next = ST_TAIL;
                    end
                    default: begin
                        cmd.anc_from_in = 1'b1;
                        if (status.last_pose) begin
                            cmd.start  = 1'b1;
                            cmd.src    = ROT_ZERO;
                            state_next = ST_RUN_ROTF;
                        end else begin
                            phase_next = 2'd1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_RUN_PEN: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_QMUL;
            end
            ST_QMUL: begin
                cmd.save_prev = 1'b1;
                cmd.qmul      = 1'b1;
                state_next    = ST_QSTART;
            end
            ST_QSTART: begin
                cmd.start  = 1'b1;
                cmd.src    = SRC_QUAT;
                state_next = ST_RUN_QUAT;
            end
            ST_RUN_QUAT: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_WO_START;
            end
            ST_WO_START: begin
                cmd.save_this = 1'b1;
                cmd.start     = 1'b1;
                cmd.src       = SRC_IN;
                state_next    = ST_RUN_WO;
            end
            ST_RUN_WO: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_GAP_DX;
            end
            ST_GAP_DX: begin
                cmd.save_wo = 1'b1;
                cmd.gap_op  = GAP_DX;
                state_next  = ST_GAP_DY;
            end
            ST_GAP_DY: begin
                cmd.gap_op = GAP_DY;
                state_next = ST_GAP_G;
            end
            ST_GAP_G: begin
                cmd.gap_op = GAP_G;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.gap_op = GAP_DECIDE;
                state_next = ST_KEEP;
            end
            ST_KEEP: begin
                // drop the pending pose unless the test kept it
                if (status.keep) begin
                    cmd.start  = 1'b1;
                    cmd.src    = ROT_PREV;
                    state_next = ST_RUN_ROTK;
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_RUN_ROTK: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_EMIT_K;
            end
            ST_EMIT_K: begin
                if (status.out_free) begin
                    cmd.out_sel      = OUT_ANCHOR;
                    cmd.anc_from_pen = 1'b1;
                    state_next       = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (status.last_pose) begin
                    cmd.start  = 1'b1;
                    cmd.src    = SRC_IN;
                    state_next = ST_RUN_HEAD;
                end else begin
                    cmd.pen_from_in = 1'b1;
                    phase_next      = 2'd2;
                    state_next      = ST_IDLE;
                end
            end
            ST_RUN_HEAD: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_HROT;
            end
            ST_HROT: begin
                cmd.start  = 1'b1;
                cmd.src    = ROT_CUR;
                state_next = ST_RUN_ROTF;
            end
            ST_RUN_ROTF: begin
                cmd.step = 1'b1;
                if (status.cordic_last) state_next = ST_EMIT_F;
            end
            ST_EMIT_F: begin
                if (status.out_free) begin
                    cmd.out_sel = OUT_ANCHOR;
                    state_next  = ST_EMIT_G;
                end
            end
            ST_EMIT_G: begin
                if (status.out_free) begin
                    cmd.out_sel = OUT_GOAL;
                    phase_next  = 2'd0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
